// ===== rtl/sssp_pkg.sv =====
// shared types and constants for the shortest path unit
`timescale 1ns / 1ps
package sssp_pkg;
  localparam int MaxNodes = 64;
  localparam int MaxEdges = 256;
  localparam int WeightBits = 16;
  localparam int NodeBits = $clog2(MaxNodes);
  localparam int EdgeBits = $clog2(MaxEdges);
  localparam int DistBits = 22;
  localparam logic [DistBits-1:0] DistMax = '1;
  localparam logic [6:0] PredNone = 7'(MaxNodes);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NODE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_EDGE_RD,
    S_EDGE_HD,
    S_EDGE,
    S_FIN_RD,
    S_OUT
  } state_t;
endpackage

// ===== rtl/single_source_shortest_path_unit.sv =====
// top level: edge store and iterative dijkstra sequencer
// clear, add, no-op and rejected items: result is offered in the cycle after accept
// query: a node scan over the n active nodes, then, for each visited node, a pass over all
// stored edges that relaxes them on one add and compare unit
// one item in work, in_tready low until taken
// rst_n (synchronous, active low) empties the edge store and sets node_count to 64
`timescale 1ns / 1ps
module single_source_shortest_path_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[1:0], edge_from[7:2], edge_to[13:8], edge_weight[29:14],
  // source_node[35:30], target_node[41:36], zeros[47:42]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], reachable[2], path_distance[24:3], predecessor_node[31:25]
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  localparam int NB = sssp_pkg::NodeBits;
  localparam int EB = sssp_pkg::EdgeBits;
  localparam int DB = sssp_pkg::DistBits;

  logic [NB-1:0] tail_mem [sssp_pkg::MaxEdges];
  logic [NB-1:0] head_mem [sssp_pkg::MaxEdges];
  logic [sssp_pkg::WeightBits-1:0] wt_mem [sssp_pkg::MaxEdges];
  logic [DB-1:0] dist_mem [sssp_pkg::MaxNodes];
  logic [6:0]    pred_mem [sssp_pkg::MaxNodes];
  // per-node flags as flip-flops; vis_r is read at one indexed place, fin_r at three
  logic [sssp_pkg::MaxNodes-1:0] fin_r, vis_r;

  sssp_pkg::state_t state_r, state_nxt;
  logic [6:0]  ncount_r;
  logic [EB:0] etotal_r;
  logic [6:0]  nodes_r;
  logic [NB:0] idx_r;
  logic [EB:0] eidx_r;
  logic [NB-1:0] src_r, dst_r, best_r;
  logic        best_ok_r;
  logic [DB-1:0] best_d_r;
  logic [31:0] out_r;
  logic        out_v_r;

  // edge read registers
  logic [NB-1:0] e_tail_r, e_head_r;
  logic [sssp_pkg::WeightBits-1:0] e_wt_r;
  logic [DB-1:0] h_dist_r;
  logic [6:0]    d_pred_r;

  logic [1:0]    act;
  logic [NB-1:0] f_from, f_to, f_src, f_dst;
  logic [sssp_pkg::WeightBits-1:0] f_wt;
  logic [6:0]    nodes_c;
  assign act    = in_tdata[1:0];
  assign f_from = in_tdata[7:2];
  assign f_to   = in_tdata[13:8];
  assign f_wt   = in_tdata[29:14];
  assign f_src  = in_tdata[35:30];
  assign f_dst  = in_tdata[41:36];
  assign nodes_c = (ncount_r == 7'd0) ? 7'd1 :
                   (ncount_r > 7'(sssp_pkg::MaxNodes)) ? 7'(sssp_pkg::MaxNodes) : ncount_r;

  logic in_acc;
  assign in_tready = (state_r == sssp_pkg::S_IDLE) && !out_v_r;
  assign in_acc = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

  function automatic logic [31:0] pack(logic [1:0] st, logic r, logic [DB-1:0] d,
                                       logic [6:0] p);
    pack = {p, d, r, st};
  endfunction

  // add-and-compare unit for edge relaxation
  logic [DB:0]   sum_w;
  logic [DB-1:0] sum_sat;
  logic          relax;
  assign sum_w = {1'b0, best_d_r} + {{(DB+1-sssp_pkg::WeightBits){1'b0}}, e_wt_r};
  assign sum_sat = sum_w[DB] ? sssp_pkg::DistMax : sum_w[DB-1:0];
  assign relax = (e_tail_r == best_r) && ({1'b0, e_head_r} < nodes_r) &&
                 (!fin_r[e_head_r] || sum_sat < h_dist_r);

  logic [NB-1:0] scan_i;
  assign scan_i = idx_r[NB-1:0];
  logic [DB-1:0] scan_d;
  always_ff @(posedge clk) scan_d <= dist_mem[scan_i];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sssp_pkg::S_IDLE:
        if (in_acc && act == sssp_pkg::ACT_QUERY && {1'b0, f_src} < nodes_c &&
            {1'b0, f_dst} < nodes_c) state_nxt = sssp_pkg::S_INIT;
      sssp_pkg::S_INIT:
        if (idx_r == nodes_r - 7'd1) state_nxt = sssp_pkg::S_SCAN;
      sssp_pkg::S_SCAN:
        if (idx_r == nodes_r + 7'd1) state_nxt = best_ok_r ? sssp_pkg::S_EDGE_RD
                                                           : sssp_pkg::S_FIN_RD;
      sssp_pkg::S_EDGE_RD:
        if (eidx_r == etotal_r) state_nxt = sssp_pkg::S_SCAN;
        else state_nxt = sssp_pkg::S_EDGE_HD;
      sssp_pkg::S_EDGE_HD: state_nxt = sssp_pkg::S_EDGE;
      sssp_pkg::S_EDGE:    state_nxt = sssp_pkg::S_EDGE_RD;
      sssp_pkg::S_FIN_RD:  state_nxt = sssp_pkg::S_OUT;
      sssp_pkg::S_OUT:     state_nxt = sssp_pkg::S_IDLE;
      default:             state_nxt = sssp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sssp_pkg::S_IDLE;
      ncount_r <= 7'(sssp_pkg::MaxNodes);
      etotal_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) ncount_r <= cfg_data;
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      if (in_acc) begin
        if (act == sssp_pkg::ACT_CLEAR) etotal_r <= '0;
        if (act == sssp_pkg::ACT_ADD && {1'b0, f_from} < nodes_c &&
            {1'b0, f_to} < nodes_c && etotal_r < (EB+1)'(sssp_pkg::MaxEdges))
          etotal_r <= etotal_r + 1'b1;
        if (state_nxt == sssp_pkg::S_IDLE) out_v_r <= 1'b1;
      end
      if (state_r == sssp_pkg::S_OUT) out_v_r <= 1'b1;
    end
  end

  // datapath and memories
  always_ff @(posedge clk) begin
    unique case (state_r)
      sssp_pkg::S_IDLE: begin
        if (in_acc) begin
          nodes_r <= nodes_c;
          src_r <= f_src;
          dst_r <= f_dst;
          idx_r <= '0;
          priority if (act == sssp_pkg::ACT_ADD &&
                       ({1'b0, f_from} >= nodes_c || {1'b0, f_to} >= nodes_c))
            out_r <= pack(sssp_pkg::ST_NODE, 1'b0, '0, sssp_pkg::PredNone);
          else if (act == sssp_pkg::ACT_ADD &&
                   etotal_r >= (EB+1)'(sssp_pkg::MaxEdges))
            out_r <= pack(sssp_pkg::ST_FULL, 1'b0, '0, sssp_pkg::PredNone);
          else if (act == sssp_pkg::ACT_QUERY &&
                   ({1'b0, f_src} >= nodes_c || {1'b0, f_dst} >= nodes_c))
            out_r <= pack(sssp_pkg::ST_NODE, 1'b0, '0, sssp_pkg::PredNone);
          else
            out_r <= pack(sssp_pkg::ST_OK, 1'b0, '0, sssp_pkg::PredNone);
          if (act == sssp_pkg::ACT_ADD && {1'b0, f_from} < nodes_c &&
              {1'b0, f_to} < nodes_c && etotal_r < (EB+1)'(sssp_pkg::MaxEdges)) begin
            tail_mem[etotal_r[EB-1:0]] <= f_from;
            head_mem[etotal_r[EB-1:0]] <= f_to;
            wt_mem[etotal_r[EB-1:0]]   <= f_wt;
          end
        end
      end
      sssp_pkg::S_INIT: begin
        dist_mem[scan_i] <= '0;
        pred_mem[scan_i] <= sssp_pkg::PredNone;
        fin_r[scan_i] <= (scan_i == src_r);
        vis_r[scan_i] <= 1'b0;
        if (state_nxt == sssp_pkg::S_SCAN) begin
          idx_r <= '0;
          best_ok_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      sssp_pkg::S_SCAN: begin
        // scan_d is a registered read and lags idx; candidate is idx_r-1
        if (idx_r != '0 && idx_r <= nodes_r) begin
          if (fin_r[scan_i - 1'b1] && !vis_r[scan_i - 1'b1] &&
              (!best_ok_r || scan_d < best_d_r)) begin
            best_ok_r <= 1'b1;
            best_r <= scan_i - 1'b1;
            best_d_r <= scan_d;
          end
        end
        if (idx_r == nodes_r + 7'd1) begin
          idx_r <= '0;
          eidx_r <= '0;
          if (best_ok_r) vis_r[best_r] <= 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      sssp_pkg::S_EDGE_RD: begin
        best_ok_r <= 1'b0;
        e_tail_r <= tail_mem[eidx_r[EB-1:0]];
        e_head_r <= head_mem[eidx_r[EB-1:0]];
        e_wt_r   <= wt_mem[eidx_r[EB-1:0]];
      end
      sssp_pkg::S_EDGE_HD: begin
        h_dist_r <= dist_mem[e_head_r];
      end
      sssp_pkg::S_EDGE: begin
        if (relax) begin
          dist_mem[e_head_r] <= sum_sat;
          pred_mem[e_head_r] <= {1'b0, best_r};
          fin_r[e_head_r] <= 1'b1;
        end
        eidx_r <= eidx_r + 1'b1;
      end
      sssp_pkg::S_FIN_RD: begin
        best_d_r <= dist_mem[dst_r];
        d_pred_r <= pred_mem[dst_r];
      end
      sssp_pkg::S_OUT: begin
        if (fin_r[dst_r]) out_r <= pack(sssp_pkg::ST_OK, 1'b1, best_d_r, d_pred_r);
        else out_r <= pack(sssp_pkg::ST_OK, 1'b0, '0, sssp_pkg::PredNone);
      end
      default: ;
    endcase
  end
endmodule

// ===== tb/sssp_checker.sv =====
// checker: watches the shortest path unit's channels, predicts and compares results
`timescale 1ns / 1ps
module sssp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [6:0]                    pred;
    logic [sssp_pkg::DistBits-1:0] path_d;
    logic                          reach;
    logic [1:0]                    status;
  } answer_t;

  logic [sssp_pkg::NodeBits-1:0]   tails [sssp_pkg::MaxEdges];
  logic [sssp_pkg::NodeBits-1:0]   heads [sssp_pkg::MaxEdges];
  logic [sssp_pkg::WeightBits-1:0] weights [sssp_pkg::MaxEdges];
  int unsigned           stored;
  logic [6:0]            node_reg;
  answer_t               answers [16];
  int unsigned           wr_n, rd_n;

  function automatic int unsigned nodes_in_use();
    if (node_reg == 0) return 1;
    if (node_reg > sssp_pkg::MaxNodes) return sssp_pkg::MaxNodes;
    return node_reg;
  endfunction

  // scan form of dijkstra, ties to the lowest index, edges in store order
  function automatic answer_t solve_path(int unsigned src, int unsigned dst,
                                         int unsigned n);
    logic [sssp_pkg::DistBits-1:0] dist_v [sssp_pkg::MaxNodes];
    bit                  fin [sssp_pkg::MaxNodes];
    bit                  seen [sssp_pkg::MaxNodes];
    logic [6:0]          pred [sssp_pkg::MaxNodes];
    int unsigned         best;
    longint unsigned     sum;
    answer_t             a;
    for (int i = 0; i < n; i++) begin
      dist_v[i] = 0; fin[i] = 0; seen[i] = 0; pred[i] = sssp_pkg::PredNone;
    end
    fin[src] = 1;
    forever begin
      best = n;
      for (int i = 0; i < n; i++)
        if (fin[i] && !seen[i] && (best == n || dist_v[i] < dist_v[best])) best = i;
      if (best == n) break;
      seen[best] = 1;
      for (int e = 0; e < stored; e++) begin
        if (tails[e] != best || heads[e] >= n) continue;
        sum = dist_v[best] + weights[e];
        if (sum > sssp_pkg::DistMax) sum = sssp_pkg::DistMax;
        if (!fin[heads[e]] || sum < dist_v[heads[e]]) begin
          dist_v[heads[e]] = sssp_pkg::DistBits'(sum);
          fin[heads[e]] = 1;
          pred[heads[e]] = 7'(best);
        end
      end
    end
    a = '{pred: sssp_pkg::PredNone, path_d: '0, reach: 1'b0, status: sssp_pkg::ST_OK};
    if (fin[dst]) begin
      a.reach = 1'b1;
      a.path_d = dist_v[dst];
      a.pred = pred[dst];
    end
    return a;
  endfunction

  function automatic answer_t apply_item(logic [47:0] d);
    sssp_pkg::action_t act;
    int unsigned n, from, to, src, dst;
    answer_t     a;
    act = sssp_pkg::action_t'(d[1:0]);
    from = d[7:2];
    to = d[13:8];
    src = d[35:30];
    dst = d[41:36];
    n = nodes_in_use();
    a = '{pred: sssp_pkg::PredNone, path_d: '0, reach: 1'b0, status: sssp_pkg::ST_OK};
    case (act)
      sssp_pkg::ACT_CLEAR: stored = 0;
      sssp_pkg::ACT_ADD: begin
        if (from >= n || to >= n) a.status = sssp_pkg::ST_NODE;
        else if (stored >= sssp_pkg::MaxEdges) a.status = sssp_pkg::ST_FULL;
        else begin
          tails[stored] = from;
          heads[stored] = to;
          weights[stored] = d[29:14];
          stored++;
        end
      end
      sssp_pkg::ACT_QUERY: begin
        if (src >= n || dst >= n) a.status = sssp_pkg::ST_NODE;
        else a = solve_path(src, dst, n);
      end
      default: ;
    endcase
    return a;
  endfunction

  assign pending = int'(wr_n - rd_n);

  always @(posedge clk) begin
    answer_t want, got;
    if (!rst_n) begin
      stored = 0;
      node_reg <= 7'd64;
      fail_count <= 0;
      wr_n <= 0;
      rd_n <= 0;
    end else begin
      if (cfg_valid && cfg_ready) node_reg <= cfg_data;
      if (in_tvalid && in_tready) begin
        answers[wr_n % 16] <= apply_item(in_tdata);
        wr_n <= wr_n + 1;
      end
      if (out_tvalid && out_tready) begin
        got = answer_t'(out_tdata);
        if (wr_n == rd_n) begin
          if (fail_count < 10) $display("unexpected result %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = answers[rd_n % 16];
          rd_n <= rd_n + 1;
          if (got !== want) begin
            if (fail_count < 10)
              $display("result: status %0d/%0d reach %0d/%0d dist %0d/%0d pred %0d/%0d",
                       want.status, got.status, want.reach, got.reach,
                       want.path_d, got.path_d, want.pred, got.pred);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// testbench top: stimulus, configuration phases and verdict for the shortest path unit
`timescale 1ns / 1ps
module tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int          stall_phase = 0;

  always #5 clk = ~clk;

  single_source_shortest_path_unit dut (.*);

  sssp_checker chk (.*);

  // receiver stalls on a repeating pattern, with stretches of no stall
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 23;
    out_tready <= (stall_phase < 10) || (stall_phase % 3 == 0);
  end

  function automatic logic [47:0] pack_item(sssp_pkg::action_t act, int from, int to,
                                            int weight, int src, int dst);
    return {6'b0, 6'(dst), 6'(src), 16'(weight), 6'(to), 6'(from), act};
  endfunction

  // one item, sent in bursts with random gaps in between
  task automatic send(logic [47:0] d);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_nodes(logic [6:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random graph: in-range edges mixed with queries, some clears and noise
  task automatic random_phase(int n, int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) send(pack_item(sssp_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
      else if (r < 55)
        send(pack_item(sssp_pkg::ACT_ADD, $urandom_range(0, n - 1),
                       $urandom_range(0, n - 1),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 50), 0, 0));
      else if (r < 90)
        send(pack_item(sssp_pkg::ACT_QUERY, 0, 0, 0, $urandom_range(0, n - 1),
                       $urandom_range(0, n - 1)));
      else send($urandom() | (48'($urandom()) << 32));
    end
  endtask

  initial begin
    #200ms;
    $display("single_source_shortest_path_unit: mismatch");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, range errors, all actions
    send(pack_item(sssp_pkg::ACT_QUERY, 0, 0, 0, 5, 5));
    send(pack_item(sssp_pkg::ACT_ADD, 0, 63, 65535, 0, 0));
    for (int i = 1; i < 21; i++)
      send(pack_item(sssp_pkg::ACT_ADD, i - 1, i, 65535, 0, 0));
    send(pack_item(sssp_pkg::ACT_QUERY, 0, 0, 0, 0, 63));
    send(pack_item(sssp_pkg::ACT_QUERY, 0, 0, 0, 63, 0));
    send(pack_item(sssp_pkg::ACT_NOP, 63, 63, 65535, 63, 63));
    send(pack_item(sssp_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
    set_nodes(7'd0);
    send(pack_item(sssp_pkg::ACT_ADD, 0, 1, 3, 0, 0));
    send(pack_item(sssp_pkg::ACT_ADD, 0, 0, 7, 0, 0));
    send(pack_item(sssp_pkg::ACT_QUERY, 0, 0, 0, 0, 1));
    send(pack_item(sssp_pkg::ACT_QUERY, 0, 0, 0, 0, 0));
    set_nodes(7'd127);
    send(pack_item(sssp_pkg::ACT_ADD, 1, 2, 3, 0, 0));
    send(pack_item(sssp_pkg::ACT_QUERY, 0, 0, 0, 3, 60));
    drain();
    send(pack_item(sssp_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
    set_nodes(7'd4);
    send(pack_item(sssp_pkg::ACT_ADD, 4, 1, 1, 0, 0));
    send(pack_item(sssp_pkg::ACT_ADD, 0, 1, 5, 0, 0));
    send(pack_item(sssp_pkg::ACT_ADD, 0, 2, 1, 0, 0));
    send(pack_item(sssp_pkg::ACT_ADD, 2, 1, 4, 0, 0));
    send(pack_item(sssp_pkg::ACT_QUERY, 0, 0, 0, 0, 1));
    send(pack_item(sssp_pkg::ACT_QUERY, 0, 0, 0, 0, 3));
    send(pack_item(sssp_pkg::ACT_QUERY, 0, 0, 0, 4, 1));
    random_phase(4, 10);
    set_nodes(7'd12);
    random_phase(12, 25);
    set_nodes(7'd64);
    random_phase(64, 20);
    set_nodes(7'd2);
    random_phase(2, 5);
    drain();
    if (fail_count == 0) $display("single_source_shortest_path_unit: match");
    else $display("single_source_shortest_path_unit: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/sssp_pkg.sv
rtl/single_source_shortest_path_unit.sv
tb/sssp_checker.sv
tb/tb.sv
